/* rtl/fdt_structure_token_parser_defines.svh */
// Assertion macros shared by the structure token parser.
// Expects signals named clk and rst in the scope of use.
`ifndef FDT_STRUCTURE_TOKEN_PARSER_DEFINES_SVH
`define FDT_STRUCTURE_TOKEN_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FDTSP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, disabled during reset.
`define FDTSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/fdtsp_pkg.sv */
// Types, token codes and helpers for the structure token parser.
// No dependencies.
`default_nettype none
package fdtsp_pkg;

  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_NOP        = 32'd4;
  localparam logic [31:0] TOK_END        = 32'd9;
  localparam logic [31:0] BYTE_MASK      = 32'h0000_00FF;
  localparam logic [2:0]  WORD_BYTES     = 3'd4;

  typedef enum logic [2:0] {
    PH_TOKEN = 3'd0,
    PH_NAME  = 3'd1,
    PH_LEN   = 3'd2,
    PH_OFF   = 3'd3,
    PH_VALUE = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    EV_BEGIN   = 4'd0,
    EV_NAME    = 4'd1,
    EV_ENDNODE = 4'd2,
    EV_NOP     = 4'd3,
    EV_PROP    = 4'd4,
    EV_LEN     = 4'd5,
    EV_NAMEOFF = 4'd6,
    EV_VALUE   = 4'd7,
    EV_END     = 4'd8,
    EV_UNKNOWN = 4'd9,
    EV_IGNORED = 4'd10
  } event_t;

  typedef struct packed {
    logic        restart;
    logic [31:0] word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  value_bytes;
    logic [31:0] payload;
    event_t      event_res;
  } result_t;

  typedef struct packed {
    phase_t phase;
    logic   finished;
    logic   bytes_nz;
  } status_t;

  function automatic logic has_zero_byte(input logic [31:0] w);
    logic found;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (((w >> (8 * i)) & BYTE_MASK) == 32'd0) begin
        found = 1'b1;
      end
    end
    return found;
  endfunction

endpackage
`default_nettype wire

/* rtl/fdtsp_in_stage.sv */
// Input register of the structure token parser.
// Depends on fdtsp_pkg.
`default_nettype none
module fdtsp_in_stage
  import fdtsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire in_item_t s_item,
  input  wire logic     adv,
  output logic          take,
  output in_item_t      item
);

  logic valid;

  assign s_tready = !valid || adv;
  assign take     = valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule
`default_nettype wire

/* rtl/fdtsp_core.sv */
// Parser state and word classification for the structure token parser.
// Depends on fdtsp_pkg.
`default_nettype none
module fdtsp_core
  import fdtsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire in_item_t item,
  output result_t       result,
  output status_t       status
);

  phase_t      phase, phase_next, eff_phase;
  logic [31:0] bytes_left, bytes_left_next, eff_bytes;
  logic        finished, finished_next, eff_fin;
  logic [2:0]  chunk;

  // A restart clears the state before the word is looked at.
  assign eff_phase = item.restart ? PH_TOKEN : phase;
  assign eff_bytes = item.restart ? 32'd0 : bytes_left;
  assign eff_fin   = item.restart ? 1'b0 : finished;
  assign chunk     = (eff_bytes >= 32'd4) ? WORD_BYTES : eff_bytes[2:0];

  always_comb begin
    phase_next      = eff_phase;
    bytes_left_next = eff_bytes;
    finished_next   = eff_fin;
    if (!eff_fin) begin
      unique case (eff_phase)
        PH_NAME: begin
          if (has_zero_byte(item.word)) begin
            phase_next = PH_TOKEN;
          end
        end
        PH_LEN: begin
          bytes_left_next = item.word;
          phase_next      = PH_OFF;
        end
        PH_OFF: begin
          phase_next = (eff_bytes == 32'd0) ? PH_TOKEN : PH_VALUE;
        end
        PH_VALUE: begin
          bytes_left_next = eff_bytes - {29'd0, chunk};
          if (eff_bytes - {29'd0, chunk} == 32'd0) begin
            phase_next = PH_TOKEN;
          end
        end
        default: begin
          phase_next = PH_TOKEN;
          priority if (item.word == TOK_BEGIN_NODE) begin
            phase_next = PH_NAME;
          end else if (item.word == TOK_PROP) begin
            phase_next = PH_LEN;
          end else if (item.word == TOK_END_NODE || item.word == TOK_NOP) begin
            phase_next = PH_TOKEN;
          end else begin
            finished_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    result.payload     = item.word;
    result.value_bytes = 3'd0;
    result.event_res   = EV_IGNORED;
    if (eff_fin) begin
      result.payload = 32'd0;
    end else begin
      unique case (eff_phase)
        PH_NAME:  result.event_res = EV_NAME;
        PH_LEN:   result.event_res = EV_LEN;
        PH_OFF:   result.event_res = EV_NAMEOFF;
        PH_VALUE: begin
          result.event_res   = EV_VALUE;
          result.value_bytes = chunk;
        end
        default: begin
          priority if (item.word == TOK_BEGIN_NODE) begin
            result.event_res = EV_BEGIN;
          end else if (item.word == TOK_END_NODE) begin
            result.event_res = EV_ENDNODE;
          end else if (item.word == TOK_PROP) begin
            result.event_res = EV_PROP;
          end else if (item.word == TOK_NOP) begin
            result.event_res = EV_NOP;
          end else if (item.word == TOK_END) begin
            result.event_res = EV_END;
          end else begin
            result.event_res = EV_UNKNOWN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TOKEN;
      bytes_left <= 32'd0;
      finished   <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      finished   <= finished_next;
    end
  end

  assign status.phase    = phase;
  assign status.finished = finished;
  assign status.bytes_nz = (bytes_left != 32'd0);

endmodule
`default_nettype wire

/* rtl/fdtsp_out_stage.sv */
// Result register of the structure token parser.
// Depends on fdtsp_pkg.
`default_nettype none
module fdtsp_out_stage
  import fdtsp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    take,
  input  wire result_t result,
  output logic         adv,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output result_t      res
);

  assign adv = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= result;
    end
  end

endmodule
`default_nettype wire

/* rtl/fdt_structure_token_parser.sv */
// Flattened device tree structure block token parser, top level.
// Labels each 32-bit structure word as a token, name word, length, offset or value.
// The input channel carries one big-endian word per transfer; tuser marks the
// first word of a new structure block and clears the parser state first.
// The output channel carries one result per input word: the event code, the
// word (or length, or string offset; zero for ignored words) and the count of
// valid bytes in a property value word.
// A result is registered: its word passes the input register and then the result
// register, and a receiver stall can hold it in either one.
// Throughput is one word per cycle unless the receiver stalls: the input register,
// a single pass of classification logic and the result register form a two-stage
// pipeline. When the receiver stalls, the result register holds its transfer; the
// input register takes one more word only if it is empty, and then tready drops.
// After an end token or an unknown tag every word is reported as ignored until
// a word arrives with the restart flag set.
// Reset clears both pipeline stages and returns the parser to expect a token.
// Depends on fdtsp_pkg, fdtsp_in_stage, fdtsp_core, fdtsp_out_stage and the assertion macros header.
`default_nettype none
`include "fdt_structure_token_parser_defines.svh"
module fdt_structure_token_parser
  import fdtsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] word
  input  wire logic        s_tuser,   // [0] restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [3:0] event_res, [35:4] payload,
                                      // [38:36] value_bytes, [39] zero
);

  in_item_t s_item, item;
  result_t  result, res;
  status_t  status;
  logic     adv, take;

  assign s_item.word    = s_tdata;
  assign s_item.restart = s_tuser;

  fdtsp_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_item  (s_item),
    .adv     (adv),
    .take    (take),
    .item    (item)
  );

  fdtsp_core u_core (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (item),
    .result(result),
    .status(status)
  );

  fdtsp_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .result  (result),
    .adv     (adv),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .res     (res)
  );

  assign m_tdata = {1'b0, res};

  `FDTSP_ASSERT_IMPL(a_value_has_bytes, status.phase == PH_VALUE, status.bytes_nz)
  `FDTSP_ASSERT_NEXT(a_finished_ignores, take && !item.restart && status.finished,
                     m_tdata[3:0] == EV_IGNORED && m_tdata[35:4] == 32'd0)
  `FDTSP_ASSERT_IMPL(a_bytes_only_value, m_tvalid && m_tdata[38:36] != 3'd0,
                     m_tdata[3:0] == EV_VALUE)

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for fdt_structure_token_parser: drives structure-block words
// with random gaps and back-pressure, and checks every labeled word against a predictor.
// Depends on fdtsp_pkg and the parser RTL.
`default_nettype none
module tb;
  import fdtsp_pkg::*;

  localparam int WORD_TARGET = 1550;
  localparam int CYCLE_LIMIT = 250000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER = 400;
  localparam int DRAIN_CYCLES = 8;

  class parse_scoreboard;
    phase_t phase;
    logic [31:0] bytes_left;
    bit finished;
    result_t expected_q[$];
    int errors;

    function new();
      clear_parse();
      errors = 0;
    endfunction

    function void clear_parse();
      phase = PH_TOKEN;
      bytes_left = '0;
      finished = 1'b0;
    endfunction

    function void note_word(logic [31:0] w, logic restart);
      result_t r;
      logic [2:0] vb;
      if (restart) begin
        clear_parse();
      end
      r.event_res = EV_IGNORED;
      r.payload = w;
      r.value_bytes = '0;
      if (finished) begin
        r.payload = '0;
      end else begin
        case (phase)
          PH_NAME: begin
            r.event_res = EV_NAME;
            if (w[7:0] == 8'd0 || w[15:8] == 8'd0 || w[23:16] == 8'd0 || w[31:24] == 8'd0) begin
              phase = PH_TOKEN;
            end
          end
          PH_LEN: begin
            r.event_res = EV_LEN;
            bytes_left = w;
            phase = PH_OFF;
          end
          PH_OFF: begin
            r.event_res = EV_NAMEOFF;
            phase = (bytes_left == '0) ? PH_TOKEN : PH_VALUE;
          end
          PH_VALUE: begin
            r.event_res = EV_VALUE;
            vb = (bytes_left >= 32'd4) ? WORD_BYTES : bytes_left[2:0];
            r.value_bytes = vb;
            bytes_left = bytes_left - {29'd0, vb};
            if (bytes_left == '0) begin
              phase = PH_TOKEN;
            end
          end
          default: begin
            phase = PH_TOKEN;
            case (w)
              TOK_BEGIN_NODE: begin
                r.event_res = EV_BEGIN;
                phase = PH_NAME;
              end
              TOK_END_NODE: r.event_res = EV_ENDNODE;
              TOK_PROP: begin
                r.event_res = EV_PROP;
                phase = PH_LEN;
              end
              TOK_NOP: r.event_res = EV_NOP;
              TOK_END: begin
                r.event_res = EV_END;
                finished = 1'b1;
              end
              default: begin
                r.event_res = EV_UNKNOWN;
                finished = 1'b1;
              end
            endcase
          end
        endcase
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [39:0] data);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: tdata %h", data);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (data[3:0] != exp_r.event_res) begin
        $error("event_res: expected %0d, actual %0d", exp_r.event_res, data[3:0]);
        errors++;
      end
      if (data[35:4] != exp_r.payload) begin
        $error("payload: expected %h, actual %h", exp_r.payload, data[35:4]);
        errors++;
      end
      if (data[38:36] != exp_r.value_bytes) begin
        $error("value_bytes: expected %0d, actual %0d", exp_r.value_bytes, data[38:36]);
        errors++;
      end
      if (data[39] != 1'b0) begin
        $error("pad: expected 0, actual %b", data[39]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;

  parse_scoreboard sb = new();
  in_item_t stim_q[$];
  int words_sent = 0;

  fdt_structure_token_parser uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void push_word(logic [31:0] w, logic restart);
    in_item_t item;
    item.word = w;
    item.restart = restart;
    stim_q.push_back(item);
  endfunction

  function automatic logic [31:0] nonzero_word();
    logic [31:0] w;
    for (int i = 0; i < 4; i++) begin
      w[8*i +: 8] = 8'($urandom_range(1, 255));
    end
    return w;
  endfunction

  function automatic void add_name();
    logic [31:0] w;
    int n;
    n = $urandom_range(0, 3);
    repeat (n) push_word(nonzero_word(), 1'b0);
    w = $urandom();
    w[8*$urandom_range(0, 3) +: 8] = 8'd0;
    push_word(w, 1'b0);
  endfunction

  function automatic void add_prop();
    logic [31:0] len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 24);
    push_word(TOK_PROP, 1'b0);
    push_word(len, 1'b0);
    push_word($urandom(), 1'b0);
    for (int i = 0; i < (len + 3) / 4; i++) begin
      push_word($urandom(), 1'b0);
    end
  endfunction

  function automatic void add_node(int depth, logic restart);
    int n;
    push_word(TOK_BEGIN_NODE, restart);
    add_name();
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        push_word(TOK_NOP, 1'b0);
      end
      add_prop();
    end
    if (depth < 2) begin
      n = $urandom_range(0, 2);
      repeat (n) add_node(depth + 1, 1'b0);
    end
    push_word(TOK_END_NODE, 1'b0);
  endfunction

  // Mostly complete trees; the rest are stray tags and trees cut off mid-way,
  // which the restart of the following block recovers from.
  function automatic void add_block();
    int n;
    n = $urandom_range(0, 99);
    if (n < 80) begin
      add_node(0, 1'b1);
      push_word(TOK_END, 1'b0);
      n = $urandom_range(0, 2);
      repeat (n) push_word($urandom(), 1'b0);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          push_word(($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 12), 1'b1);
          n = $urandom_range(0, 3);
          repeat (n) push_word($urandom(), 1'b0);
        end
        1: begin
          push_word(TOK_BEGIN_NODE, 1'b1);
          n = $urandom_range(1, 4);
          repeat (n) push_word(nonzero_word(), 1'b0);
        end
        2: begin
          push_word(TOK_PROP, 1'b1);
          push_word($urandom() | 32'h0000_0100, 1'b0);
          push_word($urandom(), 1'b0);
          n = $urandom_range(1, 3);
          repeat (n) push_word($urandom(), 1'b0);
        end
        default: begin
          push_word(TOK_NOP, 1'b1);
          push_word(TOK_PROP, 1'b0);
          push_word($urandom_range(9, 30), 1'b0);
          push_word($urandom(), 1'b0);
          push_word($urandom(), 1'b0);
        end
      endcase
    end
  endfunction

  task automatic send_word(in_item_t item);
    int gap;
    gap = ((words_sent / 80) % 4 == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= item.word;
    s_tuser <= item.restart;
    do @(posedge clk); while (!s_tready);
    sb.note_word(item.word, item.restart);
    words_sent++;
  endtask

  task automatic send_queued();
    in_item_t item;
    while (stim_q.size() > 0) begin
      item = stim_q.pop_front();
      send_word(item);
    end
  endtask

  task automatic receive_results();
    int gap;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    forever begin
      gap = ((taken / 70) % 4 == 1) ? 0 : $urandom_range(0, 11);
      if (!held && taken >= HOLD_AFTER) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_result(m_tdata);
      taken++;
    end
  endtask

  task automatic watch_cycles();
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("fdt_structure_token_parser test failed");
    $finish;
  endtask

  initial begin
    fork
      receive_results();
      watch_cycles();
    join_none
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    push_word(TOK_NOP, 1'b0);
    push_word(TOK_BEGIN_NODE, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h00FF_FFFF, 1'b0);
    push_word(TOK_PROP, 1'b0);
    push_word(32'd0, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(TOK_PROP, 1'b0);
    push_word(32'd5, 1'b0);
    push_word(32'd0, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h1234_5678, 1'b0);
    push_word(TOK_BEGIN_NODE, 1'b0);
    push_word(32'hFFFF_00FF, 1'b0);
    push_word(TOK_END_NODE, 1'b0);
    push_word(TOK_PROP, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'd3, 1'b0);
    push_word(32'hA5A5_5A5A, 1'b0);
    push_word(TOK_END, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'd0, 1'b1);
    push_word(TOK_BEGIN_NODE, 1'b0);
    push_word(TOK_BEGIN_NODE, 1'b1);
    push_word(32'hFFFF_FF00, 1'b0);
    send_queued();

    while (words_sent < WORD_TARGET) begin
      add_block();
      send_queued();
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("fdt_structure_token_parser test passed");
    end else begin
      $display("fdt_structure_token_parser test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
